// ===== design/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants of the string escape stream
// Run descriptor passed from the classifier to the serializer, character
// codes and the helpers that give the length and bytes of a run.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // bytes that steer classification
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] LEAD_E2    = 8'hE2;
  localparam logic [7:0] MID_80     = 8'h80;
  localparam logic [7:0] TAIL_A8    = 8'hA8;
  localparam logic [7:0] TAIL_A9    = 8'hA9;

  // raw control codes with short escapes
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_CR  = 8'h0D;

  // ASCII characters written to the output
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_TWO    = 8'h32;
  localparam logic [7:0] CHR_EIGHT  = 8'h38;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_UPA    = 8'h41;
  localparam logic [7:0] CHR_LB     = 8'h62;
  localparam logic [7:0] CHR_LF     = 8'h66;
  localparam logic [7:0] CHR_LN     = 8'h6E;
  localparam logic [7:0] CHR_LR     = 8'h72;
  localparam logic [7:0] CHR_LT     = 8'h74;
  localparam logic [7:0] CHR_LU     = 8'h75;

  // held prefix states
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_E2   = 2'd1;
  localparam logic [1:0] HELD_E280 = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE,   // only the flushed prefix
    KIND_RAW,    // byte as is
    KIND_PAIR,   // backslash + data
    KIND_CTRL,   // \u00XX of data
    KIND_LSEP    // \u2028 or \u2029, data is the tail byte
  } run_kind_e;

  typedef struct packed {
    logic [1:0] flush;   // held prefix bytes released first (0..2)
    run_kind_e  kind;
    logic [7:0] data;
    logic       fin;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CHR_ZERO + {4'd0, nib};
    end else begin
      r = CHR_UPA + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [3:0] run_len(input run_t run);
    logic [3:0] base;
    case (run.kind)
      KIND_NONE: base = 4'd0;
      KIND_RAW:  base = 4'd1;
      KIND_PAIR: base = 4'd2;
      KIND_CTRL: base = 4'd6;
      KIND_LSEP: base = 4'd6;
      default:   base = 4'd0;
    endcase
    return base + {2'd0, run.flush};
  endfunction

  // byte at position idx of a run
  function automatic logic [7:0] run_byte(input run_t run, input logic [2:0] idx);
    logic [7:0] r;
    logic [2:0] q;
    q = idx - {1'b0, run.flush};
    r = run.data;
    if ({1'b0, idx} < {2'd0, run.flush}) begin
      r = (idx == 3'd0) ? LEAD_E2 : MID_80;
    end else begin
      case (run.kind)
        KIND_RAW:  r = run.data;
        KIND_PAIR: r = (q == 3'd0) ? CHR_BSLASH : run.data;
        KIND_CTRL: begin
          case (q)
            3'd0:    r = CHR_BSLASH;
            3'd1:    r = CHR_LU;
            3'd2:    r = CHR_ZERO;
            3'd3:    r = CHR_ZERO;
            3'd4:    r = hex_digit(run.data[7:4]);
            default: r = hex_digit(run.data[3:0]);
          endcase
        end
        KIND_LSEP: begin
          case (q)
            3'd0:    r = CHR_BSLASH;
            3'd1:    r = CHR_LU;
            3'd2:    r = CHR_TWO;
            3'd3:    r = CHR_ZERO;
            3'd4:    r = CHR_TWO;
            default: r = (run.data == TAIL_A8) ? CHR_EIGHT : CHR_NINE;
          endcase
        end
        default:   r = run.data;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/jse_if.sv =====
// ----------------------------------------------------------------------------
// jse_in_if / jse_out_if: stream channels of the string escape block
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

// ===== design/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front: input classifier
// Tracks the held E2 / E2 80 prefix and turns each input byte into a run
// descriptor for the serializer.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  jse_in_if.sink             in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output jse_pkg::run_t      run_o
);

  logic [1:0] held_q, held_d, held_eff;
  logic       accept, emit;
  logic [7:0] b;
  logic       fin;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign fin        = in_i.in_final;
  assign held_eff   = (held_q == 2'd3) ? jse_pkg::HELD_NONE : held_q;

  always_comb begin
    held_d     = held_eff;
    emit       = 1'b1;
    run_o.flush = 2'd0;
    run_o.kind = jse_pkg::KIND_RAW;
    run_o.data = b;
    run_o.fin  = fin;
    if (held_eff == jse_pkg::HELD_E280 &&
        (b == jse_pkg::TAIL_A8 || b == jse_pkg::TAIL_A9)) begin
      run_o.kind = jse_pkg::KIND_LSEP;
      held_d     = jse_pkg::HELD_NONE;
    end else if (held_eff == jse_pkg::HELD_E2 && b == jse_pkg::MID_80 && !fin) begin
      emit   = 1'b0;
      held_d = jse_pkg::HELD_E280;
    end else begin
      run_o.flush = held_eff;
      held_d      = jse_pkg::HELD_NONE;
      if (b == jse_pkg::LEAD_E2 && !fin) begin
        held_d     = jse_pkg::HELD_E2;
        run_o.kind = jse_pkg::KIND_NONE;
        emit       = (held_eff != jse_pkg::HELD_NONE);
      end else begin
        case (b)
          jse_pkg::CHR_QUOTE:  run_o.kind = jse_pkg::KIND_PAIR;
          jse_pkg::CHR_BSLASH: run_o.kind = jse_pkg::KIND_PAIR;
          jse_pkg::CODE_BS: begin
            run_o.kind = jse_pkg::KIND_PAIR;
            run_o.data = jse_pkg::CHR_LB;
          end
          jse_pkg::CODE_FF: begin
            run_o.kind = jse_pkg::KIND_PAIR;
            run_o.data = jse_pkg::CHR_LF;
          end
          jse_pkg::CODE_LF: begin
            run_o.kind = jse_pkg::KIND_PAIR;
            run_o.data = jse_pkg::CHR_LN;
          end
          jse_pkg::CODE_CR: begin
            run_o.kind = jse_pkg::KIND_PAIR;
            run_o.data = jse_pkg::CHR_LR;
          end
          jse_pkg::CODE_HT: begin
            run_o.kind = jse_pkg::KIND_PAIR;
            run_o.data = jse_pkg::CHR_LT;
          end
          default: begin
            run_o.kind = (b < jse_pkg::CTRL_LIMIT) ? jse_pkg::KIND_CTRL
                                                   : jse_pkg::KIND_RAW;
          end
        endcase
      end
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= jse_pkg::HELD_NONE;
    end else if (accept) begin
      held_q <= held_d;
    end
  end

  // a final byte always leaves nothing held
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |=> (held_q == jse_pkg::HELD_NONE))
    else $error("prefix still held after final byte");

  // a final byte always produces output
  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |-> push_o)
    else $error("final byte produced no run");

endmodule

// ===== design/jse_queue.sv =====
// ----------------------------------------------------------------------------
// jse_queue: run descriptor queue
// Small FIFO between classifier and serializer.
// ----------------------------------------------------------------------------
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::run_t run_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output jse_pkg::run_t run_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jse_pkg::run_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign run_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("run pushed into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

// ===== design/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back: output serializer
// Walks each run descriptor one byte per cycle into the output register, while the output is ready.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jse_pkg::run_t run_i,
  output logic          pop_o,
  jse_out_if.source     out_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, text_end_q;
  logic       load, last;
  logic [3:0] len;

  assign len   = jse_pkg::run_len(run_i);
  assign last  = (idx_q == 3'(len - 4'd1));
  assign load  = q_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = load && last;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_last = run_last_q;
  assign out_o.text_end = text_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= last ? 3'd0 : idx_q + 3'd1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= jse_pkg::run_byte(run_i, idx_q);
      run_last_q <= last;
      text_end_q <= last && run_i.fin;
    end
  end

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && text_end_q) |-> run_last_q)
    else $error("text end without run end");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && run_last_q))
    else $error("run popped without marking its last byte");

endmodule

// ===== design/js_string_escape_stream.sv =====
// ----------------------------------------------------------------------------
// js_string_escape_stream: JavaScript string literal escaper
// Byte stream in, escaped text out, with held-prefix line separator match.
// ----------------------------------------------------------------------------
// The block takes one byte of a string per transfer and returns its escaped
// form one byte per transfer. An accepted byte is classified combinationally,
// written into the run queue and then serialized into the output register.
// The output side sets the rate: one output byte per cycle while the sink is
// ready, each run sent as its bytes in order: a byte that stays as it is gives
// one byte, a two-character escape two, and \u00XX or \u2028/\u2029 six, plus
// one for each held E2 or 80 prefix byte flushed in front of it. Input
// transfers keep flowing at one per cycle until the run queue (QueueDepth
// entries) fills behind a long escape. A byte that only extends a held E2 /
// E2 80 prefix produces no output. run_last marks the last byte caused by an
// input byte and text_end the last byte of a string.
// ----------------------------------------------------------------------------
module js_string_escape_stream #(
  parameter int unsigned QueueDepth = jse_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);

  // classifier to queue
  logic          push;
  jse_pkg::run_t push_run;
  logic          q_full;

  // queue to serializer
  logic          q_valid;
  logic          pop;
  jse_pkg::run_t head_run;

  // front: prefix tracking and byte classification
  jse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .run_o    (push_run)
  );

  // decouples input transfers from multi-byte escapes
  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (push_run),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .run_o   (head_run)
  );

  // back: one escaped byte per cycle into the output register, while the output is ready
  jse_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .run_i     (head_run),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ===== test/js_string_escape_stream_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// js_string_escape_stream_tb: self-checking bench of the string escaper
// Streams directed and random strings into the block, predicts the escaped
// text per input byte and compares every output transfer in order.
// ----------------------------------------------------------------------------
module js_string_escape_stream_tb;

  localparam int unsigned RandomBytes = 355;
  localparam int unsigned MaxWait     = 13;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned CycleLimit  = 200000;
  localparam string       HexDigits   = "0123456789ABCDEF";

  // one input byte of a string
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } str_byte_t;

  // one escaped output byte with its markers
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } esc_byte_t;

  logic clk_i;
  logic rst_ni;

  jse_in_if  in_if ();
  jse_out_if out_if ();

  js_string_escape_stream u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  str_byte_t   string_q[$];   // bytes still to be sent
  esc_byte_t   escaped_q[$];  // escaped text still to arrive
  logic [1:0]  held_cnt;      // predicted count of held E2 / E2 80 prefix bytes
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned sink_hold;
  bit          in_busy;
  bit          out_busy;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per failure, every failure counted.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor: escapes one accepted byte and queues the resulting text.
  // A byte that only extends a held prefix adds nothing.
  // --------------------------------------------------------------------------
  task automatic escape_predict(input logic [7:0] b, input logic fin);
    logic [7:0] txt[$];
    esc_byte_t  e;
    if (held_cnt == jse_pkg::HELD_E280 &&
        (b == jse_pkg::TAIL_A8 || b == jse_pkg::TAIL_A9)) begin
      // full line / paragraph separator: \u2028 or \u2029
      txt = '{jse_pkg::CHR_BSLASH, jse_pkg::CHR_LU, jse_pkg::CHR_TWO,
              jse_pkg::CHR_ZERO, jse_pkg::CHR_TWO,
              (b == jse_pkg::TAIL_A8) ? jse_pkg::CHR_EIGHT : jse_pkg::CHR_NINE};
      held_cnt = jse_pkg::HELD_NONE;
    end else if (held_cnt == jse_pkg::HELD_E2 && b == jse_pkg::MID_80 && !fin) begin
      held_cnt = jse_pkg::HELD_E280;
    end else begin
      // match failed or string ends: release held bytes raw
      if (held_cnt != jse_pkg::HELD_NONE) txt.push_back(jse_pkg::LEAD_E2);
      if (held_cnt == jse_pkg::HELD_E280) txt.push_back(jse_pkg::MID_80);
      held_cnt = jse_pkg::HELD_NONE;
      if (b == jse_pkg::LEAD_E2 && !fin) begin
        held_cnt = jse_pkg::HELD_E2;
      end else begin
        case (b)
          jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH:
            txt = {txt, jse_pkg::CHR_BSLASH, b};
          jse_pkg::CODE_BS: txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LB};
          jse_pkg::CODE_FF: txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LF};
          jse_pkg::CODE_LF: txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LN};
          jse_pkg::CODE_CR: txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LR};
          jse_pkg::CODE_HT: txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LT};
          default: begin
            if (b < jse_pkg::CTRL_LIMIT) begin
              txt = {txt, jse_pkg::CHR_BSLASH, jse_pkg::CHR_LU, jse_pkg::CHR_ZERO,
                     jse_pkg::CHR_ZERO,
                     8'(HexDigits[b[7:4]]), 8'(HexDigits[b[3:0]])};
            end else begin
              txt.push_back(b);
            end
          end
        endcase
      end
    end
    foreach (txt[i]) begin
      e.data     = txt[i];
      e.run_last = (i == txt.size() - 1);
      e.text_end = (i == txt.size() - 1) && fin;
      escaped_q.push_back(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_string(input logic [7:0] bytes[$]);
    str_byte_t s;
    foreach (bytes[i]) begin
      s.data = bytes[i];
      s.fin  = (i == bytes.size() - 1);
      string_q.push_back(s);
    end
  endtask

  // random string: mostly separator sequences, prefixes of them and escapable
  // characters, the rest arbitrary bytes
  task automatic queue_random_string();
    logic [7:0] bytes[$];
    int unsigned len;
    logic [7:0]  esc_set[8];
    esc_set = '{jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CODE_BS,
                jse_pkg::CODE_HT, jse_pkg::CODE_LF, jse_pkg::CODE_FF,
                jse_pkg::CODE_CR, 8'h7F};
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          case ($urandom_range(0, 5))
            0, 1: bytes = {bytes, jse_pkg::LEAD_E2, jse_pkg::MID_80,
                           $urandom_range(0, 1) ? jse_pkg::TAIL_A9
                                                : jse_pkg::TAIL_A8};
            2:    bytes = {bytes, jse_pkg::LEAD_E2, jse_pkg::MID_80,
                           8'($urandom_range(0, 255))};
            3:    bytes = {bytes, jse_pkg::LEAD_E2, 8'($urandom_range(0, 255))};
            4:    bytes.push_back(jse_pkg::LEAD_E2);
            default: bytes = {bytes, jse_pkg::LEAD_E2, jse_pkg::MID_80};
          endcase
        end
        3, 4:    bytes.push_back(esc_set[$urandom_range(0, 7)]);
        5:       bytes.push_back(8'($urandom_range(0, 31)));
        default: bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    queue_string(bytes);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued bytes, idles a drawn number of cycles between
  // transfers, in phases that switch between busy and back-to-back.
  // Prediction is done on the transfer edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    str_byte_t nxt;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.in_byte  <= '0;
      in_if.in_final <= 1'b0;
      send_gap       <= 0;
      held_cnt       = jse_pkg::HELD_NONE;
    end else begin
      if (in_if.valid && in_if.ready) begin
        escape_predict(in_if.in_byte, in_if.in_final);
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (string_q.size() != 0) begin
          nxt = string_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.in_byte  <= nxt.data;
          in_if.in_final <= nxt.fin;
          if ($urandom_range(0, 31) == 0) in_busy = !in_busy;
          send_gap <= in_busy ? $urandom_range(0, MaxWait) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transfer against the oldest expected byte and
  // stalls ready for a drawn number of cycles after each transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    esc_byte_t   exp_b;
    int unsigned h;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_hold    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (escaped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte 0x%02h", out_if.out_byte));
        end else begin
          exp_b = escaped_q.pop_front();
          if (out_if.out_byte !== exp_b.data)
            report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                      out_if.out_byte, exp_b.data));
          if (out_if.run_last !== exp_b.run_last)
            report_mismatch($sformatf("run_last %b, expected %b on byte 0x%02h",
                                      out_if.run_last, exp_b.run_last, exp_b.data));
          if (out_if.text_end !== exp_b.text_end)
            report_mismatch($sformatf("text_end %b, expected %b on byte 0x%02h",
                                      out_if.text_end, exp_b.text_end, exp_b.data));
        end
        if ($urandom_range(0, 31) == 0) out_busy = !out_busy;
        h = out_busy ? $urandom_range(0, MaxWait) : 0;
        out_if.ready <= (h == 0);
        sink_hold    <= h;
      end else if (sink_hold != 0) begin
        out_if.ready <= (sink_hold == 1);
        sink_hold    <= sink_hold - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    in_if.in_final = 1'b0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    cycle_cnt      = 0;
    err_cnt        = 0;
    in_busy        = 1'b1;
    out_busy       = 1'b1;
    held_cnt       = jse_pkg::HELD_NONE;

    // every short escape, the \u00XX range ends, space, DEL and 0xFF
    queue_string('{jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CODE_BS,
                   jse_pkg::CODE_FF, jse_pkg::CODE_LF, jse_pkg::CODE_CR,
                   jse_pkg::CODE_HT, 8'h00, 8'h1F, 8'h20, 8'h7F, 8'hFF});
    // complete line separator, final on the tail
    queue_string('{jse_pkg::LEAD_E2, jse_pkg::MID_80, jse_pkg::TAIL_A8});
    // failed lead that restarts the prefix, then paragraph separator
    queue_string('{jse_pkg::LEAD_E2, jse_pkg::LEAD_E2, jse_pkg::MID_80,
                   jse_pkg::TAIL_A9});
    // E2 80 broken by a new lead that is also the final byte
    queue_string('{jse_pkg::LEAD_E2, jse_pkg::MID_80, jse_pkg::LEAD_E2});
    // held prefixes flushed by the end of the string
    queue_string('{jse_pkg::LEAD_E2});
    queue_string('{jse_pkg::LEAD_E2, jse_pkg::MID_80});

    while (string_q.size() < 25 + RandomBytes) queue_random_string();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all bytes transferred, then all text back, then let the pipe settle
    while (string_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && escaped_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
